// ----- design/sdtq_pkg.sv -----
// Shared types and codes for the sorted deadline timer queue.
package sdtq_pkg;

  localparam int FuncW     = 2;
  localparam int IdW       = 6;
  localparam int IvlW      = 32;
  localparam int TagW      = 32;
  localparam int NowW      = 47;
  localparam int DlW       = 48;
  localparam int StatusW   = 2;

  localparam logic [FuncW-1:0] FuncSet    = 2'd0;
  localparam logic [FuncW-1:0] FuncCancel = 2'd1;
  localparam logic [FuncW-1:0] FuncUpdate = 2'd2;
  localparam logic [FuncW-1:0] FuncTick   = 2'd3;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoFree  = 2'd1;
  localparam logic [StatusW-1:0] StInact   = 2'd2;
  localparam logic [StatusW-1:0] StExpired = 2'd3;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,      // latch input word, read lookups
    CmdAlloc,     // pop free stack, write timer entry
    CmdUnlink,    // unlink current handle
    CmdFree,      // clear active, push free stack
    CmdRestart,   // new deadline from stored period
    CmdInsStart,  // begin sorted insert scan from tail
    CmdInsStep,   // compare one list entry and step back
    CmdTickHead,  // select list head as current handle
    CmdEmit       // fill output register
  } cmd_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [StatusW-1:0]   status;
    logic                 last;
    logic                 tag_zero;
    logic                 set_tick;
  } ctl_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             free_empty;
    logic             id_active;
    logic             list_empty;
    logic             ins_found;    // insert position reached
    logic             ins_done;     // insert scan exhausted
    logic             head_due;
    logic             tick_ahead;
  } sts_t;

endpackage

// ----- design/sdtq_datapath.sv -----
// Timer storage, linked order list, free stack and output register.
module sdtq_datapath #(
  parameter int NumTimers = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdtq_pkg::ctl_t                ctl_i,
  output sdtq_pkg::sts_t                sts_o,
  input  logic [sdtq_pkg::FuncW-1:0]    func_i,
  input  logic [sdtq_pkg::IdW-1:0]      timer_id_i,
  input  logic [sdtq_pkg::IvlW-1:0]     timeout_i,
  input  logic [sdtq_pkg::TagW-1:0]     user_tag_i,
  input  logic [sdtq_pkg::NowW-1:0]     now_ms_i,
  output logic [sdtq_pkg::StatusW-1:0]  status_o,
  output logic [sdtq_pkg::IdW-1:0]      handle_o,
  output logic [sdtq_pkg::TagW-1:0]     tag_out_o,
  output logic                          last_o
);
  localparam int HW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CW = $clog2(NumTimers + 1);
  localparam int DlW = sdtq_pkg::DlW;

  logic [DlW-1:0]            dl_mem  [NumTimers];
  logic [sdtq_pkg::IvlW-1:0] per_mem [NumTimers];
  logic [sdtq_pkg::TagW-1:0] tag_mem [NumTimers];
  logic [HW-1:0]             nxt_mem [NumTimers];
  logic [HW-1:0]             prv_mem [NumTimers];
  logic [HW-1:0]             stk_mem [NumTimers];
  logic [NumTimers-1:0]      act_q;
  logic                      stk_init_q;

  logic [HW-1:0] head_q, tail_q, cur_q, pos_q;
  logic [CW-1:0] act_cnt_q, free_cnt_q, scan_q;
  logic [DlW-1:0] last_tick_q, cur_dl_q;
  logic [sdtq_pkg::FuncW-1:0] func_q;
  logic [sdtq_pkg::IdW-1:0]   id_q;
  logic [sdtq_pkg::IvlW-1:0]  ivl_q;
  logic [sdtq_pkg::TagW-1:0]  tag_q;
  logic [DlW-1:0]             now_q;
  logic                       id_in_q;

  // Free stack: entries valid through an init flag until first push
  logic [HW-1:0] stk_top;
  logic [CW-1:0] fc_m1;
  assign fc_m1 = free_cnt_q - CW'(1);
  assign stk_top = stk_init_q ? stk_mem[fc_m1[HW-1:0]]
                              : HW'(NumTimers - 1) - fc_m1[HW-1:0];

  // Insert scan compare
  logic ins_gt;
  assign ins_gt = cur_dl_q > dl_mem[pos_q];

  assign sts_o.func       = func_q;
  assign sts_o.free_empty = (free_cnt_q == '0);
  assign sts_o.id_active  = id_in_q && act_q[id_q[HW-1:0]];
  assign sts_o.list_empty = (act_cnt_q == '0);
  assign sts_o.ins_found  = ins_gt;
  assign sts_o.ins_done   = (scan_q == act_cnt_q);
  assign sts_o.head_due   = (act_cnt_q != '0) && (now_q >= dl_mem[head_q]);
  assign sts_o.tick_ahead = now_q > last_tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= '0;
      stk_init_q  <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      act_cnt_q   <= '0;
      free_cnt_q  <= CW'(NumTimers);
      last_tick_q <= '0;
    end else begin
      case (ctl_i.cmd)
        sdtq_pkg::CmdAlloc: begin
          free_cnt_q <= fc_m1;
          act_q[stk_top] <= 1'b1;
        end
        sdtq_pkg::CmdUnlink: begin
          if (cur_q == head_q) head_q <= nxt_mem[cur_q];
          if (cur_q == tail_q) tail_q <= prv_mem[cur_q];
          if (act_cnt_q != '0) act_cnt_q <= act_cnt_q - CW'(1);
        end
        sdtq_pkg::CmdFree: begin
          act_q[cur_q] <= 1'b0;
          if (free_cnt_q < CW'(NumTimers)) begin
            free_cnt_q <= free_cnt_q + CW'(1);
            if (!stk_init_q) stk_init_q <= 1'b1;
          end
        end
        sdtq_pkg::CmdInsStart: begin
          if (act_cnt_q == '0) begin
            head_q    <= cur_q;
            tail_q    <= cur_q;
            act_cnt_q <= CW'(1);
          end
        end
        sdtq_pkg::CmdInsStep: begin
          if (scan_q != act_cnt_q && ins_gt) begin
            if (pos_q == tail_q) tail_q <= cur_q;
            act_cnt_q <= act_cnt_q + CW'(1);
          end else if (scan_q == act_cnt_q) begin
            head_q    <= cur_q;
            act_cnt_q <= act_cnt_q + CW'(1);
          end
        end
        default: ;
      endcase
      if (ctl_i.set_tick) last_tick_q <= now_q;
    end
  end

  // Stack contents: first push materializes the reset order
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd == sdtq_pkg::CmdFree && free_cnt_q < CW'(NumTimers)) begin
      for (int i = 0; i < NumTimers; i++) begin
        if (!stk_init_q && i != int'(free_cnt_q))
          stk_mem[i] <= HW'(NumTimers - 1 - i);
      end
      stk_mem[free_cnt_q[HW-1:0]] <= cur_q;
    end
  end

  // Payload registers and entry stores
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      sdtq_pkg::CmdLoad: begin
        func_q  <= func_i;
        id_q    <= timer_id_i;
        id_in_q <= ({1'b0, timer_id_i} < (sdtq_pkg::IdW + 1)'(NumTimers));
        ivl_q   <= timeout_i;
        tag_q   <= user_tag_i;
        now_q   <= DlW'(now_ms_i);
        cur_q   <= timer_id_i[HW-1:0];
      end
      sdtq_pkg::CmdAlloc: begin
        cur_q            <= stk_top;
        tag_mem[stk_top] <= tag_q;
        per_mem[stk_top] <= ivl_q;
        dl_mem[stk_top]  <= now_q + DlW'(ivl_q);
        cur_dl_q         <= now_q + DlW'(ivl_q);
      end
      sdtq_pkg::CmdUnlink: begin
        if (cur_q != head_q) nxt_mem[prv_mem[cur_q]] <= nxt_mem[cur_q];
        if (cur_q != tail_q) prv_mem[nxt_mem[cur_q]] <= prv_mem[cur_q];
      end
      sdtq_pkg::CmdRestart: begin
        dl_mem[cur_q] <= now_q + DlW'(per_mem[cur_q]);
        cur_dl_q      <= now_q + DlW'(per_mem[cur_q]);
      end
      sdtq_pkg::CmdInsStart: begin
        pos_q  <= tail_q;
        scan_q <= '0;
      end
      sdtq_pkg::CmdInsStep: begin
        if (scan_q != act_cnt_q && ins_gt) begin
          prv_mem[cur_q] <= pos_q;
          if (pos_q != tail_q) begin
            nxt_mem[cur_q]          <= nxt_mem[pos_q];
            prv_mem[nxt_mem[pos_q]] <= cur_q;
          end
          nxt_mem[pos_q] <= cur_q;
        end else if (scan_q == act_cnt_q) begin
          nxt_mem[cur_q]  <= head_q;
          prv_mem[head_q] <= cur_q;
        end else begin
          pos_q  <= prv_mem[pos_q];
          scan_q <= scan_q + CW'(1);
        end
      end
      sdtq_pkg::CmdTickHead: cur_q <= head_q;
      sdtq_pkg::CmdEmit: begin
        status_o <= ctl_i.status;
        last_o   <= ctl_i.last;
        if (ctl_i.status == sdtq_pkg::StNoFree) handle_o <= '0;
        else if (ctl_i.status == sdtq_pkg::StInact) handle_o <= id_q;
        else handle_o <= sdtq_pkg::IdW'(cur_q);
        if (ctl_i.tag_zero) tag_out_o <= '0;
        else tag_out_o <= tag_mem[cur_q];
      end
      default: ;
    endcase
  end
endmodule

// ----- design/sdtq_ctrl.sv -----
// Sequencing state machine for the timer queue.
module sdtq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sdtq_pkg::sts_t sts_i,
  output sdtq_pkg::ctl_t ctl_o
);
  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SDecode  = 4'd1;
  localparam logic [3:0] SAfter   = 4'd3;
  localparam logic [3:0] SInsInit = 4'd4;
  localparam logic [3:0] SInsStep = 4'd5;
  localparam logic [3:0] SEmitOne = 4'd6;
  localparam logic [3:0] STickChk = 4'd8;
  localparam logic [3:0] STickUnl = 4'd9;
  localparam logic [3:0] STickFre = 4'd10;
  localparam logic [3:0] STickEmt = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic [1:0] st_q, st_d;

  // a waiting result word does not hold off the next input word
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d     = state_q;
    ovalid_d    = ovalid_q;
    st_d        = st_q;
    ctl_o       = '{cmd: sdtq_pkg::CmdNone, status: st_q, last: 1'b1,
                    tag_zero: 1'b1, set_tick: 1'b0};
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctl_o.cmd = sdtq_pkg::CmdLoad;
          state_d   = SDecode;
        end
      end
      SDecode: begin
        case (sts_i.func)
          sdtq_pkg::FuncSet: begin
            if (sts_i.free_empty) begin
              st_d = sdtq_pkg::StNoFree;
              state_d = SEmitOne;
            end else begin
              ctl_o.cmd = sdtq_pkg::CmdAlloc;
              st_d = sdtq_pkg::StOk;
              state_d = SInsInit;
            end
          end
          sdtq_pkg::FuncTick: begin
            if (sts_i.tick_ahead) begin
              ctl_o.set_tick = 1'b1;
              state_d = STickChk;
            end else state_d = SIdle;
          end
          default: begin
            if (!sts_i.id_active) begin
              st_d = sdtq_pkg::StInact;
              state_d = SEmitOne;
            end else begin
              st_d = sdtq_pkg::StOk;
              ctl_o.cmd = sdtq_pkg::CmdUnlink;
              state_d = SAfter;
            end
          end
        endcase
      end
      SAfter: begin
        if (sts_i.func == sdtq_pkg::FuncCancel) begin
          ctl_o.cmd = sdtq_pkg::CmdFree;
          state_d = SEmitOne;
        end else begin
          ctl_o.cmd = sdtq_pkg::CmdRestart;
          state_d = SInsInit;
        end
      end
      SInsInit: begin
        ctl_o.cmd = sdtq_pkg::CmdInsStart;
        state_d = sts_i.list_empty ? SEmitOne : SInsStep;
      end
      SInsStep: begin
        ctl_o.cmd = sdtq_pkg::CmdInsStep;
        if (sts_i.ins_done || sts_i.ins_found) state_d = SEmitOne;
      end
      SEmitOne: begin
        if (!ovalid_q || out_ready_i) begin
          ctl_o.cmd = sdtq_pkg::CmdEmit;
          ctl_o.tag_zero = (sts_i.func != sdtq_pkg::FuncSet) ||
                           (st_q == sdtq_pkg::StNoFree);
          ovalid_d = 1'b1;
          state_d = SIdle;
        end
      end
      STickChk: begin
        if (sts_i.head_due) begin
          ctl_o.cmd = sdtq_pkg::CmdTickHead;
          state_d = STickUnl;
        end else state_d = SIdle;
      end
      STickUnl: begin
        ctl_o.cmd = sdtq_pkg::CmdUnlink;
        state_d = STickFre;
      end
      STickFre: begin
        ctl_o.cmd = sdtq_pkg::CmdFree;
        state_d = STickEmt;
      end
      STickEmt: begin
        // last is known once the next head is checked
        if (!ovalid_q || out_ready_i) begin
          ctl_o.cmd = sdtq_pkg::CmdEmit;
          ctl_o.status = sdtq_pkg::StExpired;
          ctl_o.tag_zero = 1'b0;
          ctl_o.last = !sts_i.head_due;
          ovalid_d = 1'b1;
          state_d = sts_i.head_due ? STickChk : SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      ovalid_q    <= 1'b0;
      st_q        <= sdtq_pkg::StOk;
    end else begin
      state_q     <= state_d;
      ovalid_q    <= ovalid_d;
      st_q        <= st_d;
    end
  end
endmodule

// ----- design/sorted_deadline_timer_queue.sv -----
// Top level of the sorted deadline timer queue.
// A pool of NUM_TIMERS timers kept in one deadline-ordered linked list.
// One word is taken at a time; the next word may be accepted while a result
// word still waits on m_axis_tready. Set, cancel and update give one result
// word; a tick gives one expiry word per due timer (tlast on the final one)
// or none. Set and update walk the list back from the tail, one entry per
// cycle. A tick that expires the whole pool is the longest operation.
// Each result word also waits as long as m_axis_tready holds it off.
module sorted_deadline_timer_queue #(
  parameter int NUM_TIMERS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], timer_id[7:2], timeout[39:8], user_tag[71:40],
  // now_ms[118:72], zero fill [119]
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], handle[7:2], tag_out[39:8]
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);
  sdtq_pkg::ctl_t ctl;
  sdtq_pkg::sts_t sts;
  logic [sdtq_pkg::StatusW-1:0] status;
  logic [sdtq_pkg::IdW-1:0]     handle;
  logic [sdtq_pkg::TagW-1:0]    tag_out;

  sdtq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  sdtq_datapath #(.NumTimers(NUM_TIMERS)) u_dp (
    .clk_i, .rst_ni,
    .ctl_i        (ctl),
    .sts_o        (sts),
    .func_i       (s_axis_tdata[1:0]),
    .timer_id_i   (s_axis_tdata[7:2]),
    .timeout_i    (s_axis_tdata[39:8]),
    .user_tag_i   (s_axis_tdata[71:40]),
    .now_ms_i     (s_axis_tdata[118:72]),
    .status_o     (status),
    .handle_o     (handle),
    .tag_out_o    (tag_out),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {tag_out, handle, status};
endmodule
